// ===== rtl/mtt_pkg.sv =====
package mtt_pkg;

    localparam int ID_W   = 16;
    localparam int IVL_W  = 31;
    localparam int TIME_W = 32;
    localparam int REQ_W  = 2;

    // request codes; code 3 is unused and does nothing
    typedef enum logic [REQ_W-1:0] {
        REQ_CREATE = 2'd0,
        REQ_STOP   = 2'd1,
        REQ_TICK   = 2'd2
    } t_req_type;

    // request as held by the top level for the whole scan
    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [ID_W-1:0]   timer_id;
        logic [IVL_W-1:0]  interval;
        logic              repeat_flag;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] create_dl;
    } t_req;

    // broadcast to every cell
    typedef struct packed {
        logic step;
        t_req req;
    } t_ctl;

    // passed from one cell to the next
    typedef struct packed {
        logic tok;
        logic placed;
    } t_link;

    // expiry report from a cell
    typedef struct packed {
        logic            fire;
        logic [ID_W-1:0] id;
    } t_fire;

    // base + delta, saturating at all ones
    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] base,
                                                  input logic [IVL_W-1:0]  delta);
        logic [TIME_W:0] sum;
        sum = {1'b0, base} + {{(TIME_W + 1 - IVL_W){1'b0}}, delta};
        return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
    endfunction

endpackage

// ===== rtl/mtt_if.sv =====
interface mtt_req_if;
    import mtt_pkg::*;

    logic                valid;
    logic                ready;
    logic [REQ_W-1:0]    req_type;
    logic [ID_W-1:0]     timer_id;
    logic [IVL_W-1:0]    interval_ms;
    logic                repeat_flag;
    logic [TIME_W-1:0]   now_ms;

    modport source (output valid, req_type, timer_id, interval_ms, repeat_flag, now_ms,
                    input ready);
    modport sink   (input valid, req_type, timer_id, interval_ms, repeat_flag, now_ms,
                    output ready);
endinterface

interface mtt_res_if;
    import mtt_pkg::*;

    logic                valid;
    logic                ready;
    logic [ID_W-1:0]     fired_id;
    logic                last_fired;

    modport source (output valid, fired_id, last_fired, input ready);
    modport sink   (input valid, fired_id, last_fired, output ready);
endinterface

// ===== rtl/mtt_cell.sv =====
module mtt_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  mtt_pkg::t_ctl  i_ctl,
    input  mtt_pkg::t_link i_link,
    output mtt_pkg::t_link o_link,
    output mtt_pkg::t_fire o_fire
);
    import mtt_pkg::*;

    logic              r_tok;
    logic              r_plc;
    logic              r_active;
    logic [ID_W-1:0]   r_id;
    logic              r_rep;
    logic [IVL_W-1:0]  r_ivl;
    logic [TIME_W-1:0] r_dl;

    logic              n_active;
    logic [TIME_W-1:0] n_dl;
    logic              w_here;
    logic              w_expired;
    logic              w_is_create;
    logic              w_is_stop;
    logic              w_is_tick;
    logic              w_do_create;
    logic              w_do_stop;
    logic              w_do_fire;

    // decode what this slot does when the token passes
    always_comb begin
        w_here      = r_tok & i_ctl.step;
        w_is_create = (i_ctl.req.req_type == REQ_CREATE);
        w_is_stop   = (i_ctl.req.req_type == REQ_STOP);
        w_is_tick   = (i_ctl.req.req_type == REQ_TICK);
        w_expired   = r_active && (r_dl <= i_ctl.req.now);
        w_do_create = w_here & w_is_create & ~r_plc & ~r_active;
        w_do_stop   = w_here & w_is_stop & r_active & (r_id == i_ctl.req.timer_id);
        w_do_fire   = w_here & w_is_tick & w_expired;
    end

    // next slot state
    always_comb begin
        n_active = r_active;
        n_dl     = r_dl;
        if (w_do_create) begin
            n_active = 1'b1;
            n_dl     = i_ctl.req.create_dl;
        end else if (w_do_stop) begin
            n_active = 1'b0;
        end else if (w_do_fire) begin
            if (r_rep) begin
                n_dl = sat_add(i_ctl.req.now, r_ivl);
            end else begin
                n_active = 1'b0;
            end
        end
    end

    // to the neighbor: token, and whether a free slot was already taken
    assign o_link.tok    = r_tok;
    assign o_link.placed = r_plc | ~r_active;

    // expiry report, valid while the token sits here
    assign o_fire.fire = r_tok & w_is_tick & w_expired;
    assign o_fire.id   = r_id;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok    <= 1'b0;
            r_plc    <= 1'b0;
            r_active <= 1'b0;
        end else begin
            if (i_ctl.step) begin
                r_tok <= i_link.tok;
                r_plc <= i_link.placed;
            end
            r_active <= n_active;
        end
    end

    // slot payload
    always_ff @(posedge i_clk) begin
        r_dl <= n_dl;
        if (w_do_create) begin
            r_id  <= i_ctl.req.timer_id;
            r_rep <= i_ctl.req.repeat_flag;
            r_ivl <= i_ctl.req.interval;
        end
    end

endmodule

// ===== rtl/multi_timer_table.sv =====
// Channel  | Dir | Fields                                              | Handshake
// i_req    | in  | req_type, timer_id, interval_ms, repeat_flag, now_ms | valid/ready
// o_res    | out | fired_id, last_fired                                | valid/ready
//
// A token walks the row of slot cells, one cell per cycle, and the block
// takes no new request until the walk and its final report are done.
// The token only advances while the output register can take a report;
// a stalled result sink holds the walk in place. One expiry is held back
// so the final report of a tick can carry last_fired.
// Synchronous active-low reset clears every slot to inactive and time to zero.
module multi_timer_table #(
    parameter int TIMER_SLOTS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mtt_req_if.sink       i_req,
    mtt_res_if.source     o_res
);
    import mtt_pkg::*;

    logic              r_busy;
    logic              r_flush;
    logic              r_launch;
    t_req              r_req;
    logic [TIME_W-1:0] r_time;
    logic              r_pend_v;
    logic [ID_W-1:0]   r_pend_id;
    logic              r_out_v;
    logic [ID_W-1:0]   r_out_id;
    logic              r_out_last;

    logic              w_accept;
    logic              w_out_free;
    logic              w_step;
    logic [IVL_W-1:0]  w_ivl;
    logic              w_fire;
    logic [ID_W-1:0]   w_fire_id;
    logic              w_push_mid;
    logic              w_push_end;
    logic              w_scan_end;
    t_ctl              w_ctl;
    t_link             w_link [TIMER_SLOTS+1];
    t_fire             w_cell_fire [TIMER_SLOTS];

    // request handshake and walk control
    assign i_req.ready = ~r_busy;
    assign w_accept    = i_req.valid & ~r_busy;
    assign w_out_free  = ~r_out_v | o_res.ready;
    assign w_step      = r_busy & ~r_flush & w_out_free;
    assign w_ivl       = (i_req.interval_ms == '0) ? IVL_W'(1) : i_req.interval_ms;

    assign w_ctl.step = w_step;
    assign w_ctl.req  = r_req;

    // chain of slot cells
    assign w_link[0].tok    = r_launch;
    assign w_link[0].placed = 1'b0;

    for (genvar g = 0; g < TIMER_SLOTS; g++) begin : g_cell
        mtt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_link  (w_link[g]),
            .o_link  (w_link[g+1]),
            .o_fire  (w_cell_fire[g])
        );
    end

    // only the cell holding the token can report
    always_comb begin
        w_fire    = 1'b0;
        w_fire_id = '0;
        for (int k = 0; k < TIMER_SLOTS; k++) begin
            w_fire    = w_fire | w_cell_fire[k].fire;
            w_fire_id = w_fire_id | (w_cell_fire[k].id & {ID_W{w_cell_fire[k].fire}});
        end
    end

    assign w_scan_end = w_step & w_link[TIMER_SLOTS].tok;
    assign w_push_mid = w_step & w_fire & r_pend_v;
    assign w_push_end = r_flush & r_pend_v & w_out_free;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_flush  <= 1'b0;
            r_launch <= 1'b0;
            r_time   <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy   <= 1'b1;
                r_launch <= 1'b1;
                if (i_req.req_type == REQ_TICK) begin
                    r_time <= i_req.now_ms;
                end
            end else if (r_flush && (!r_pend_v || w_out_free)) begin
                r_busy  <= 1'b0;
                r_flush <= 1'b0;
            end
            if (w_step) begin
                r_launch <= 1'b0;
            end
            if (w_scan_end) begin
                r_flush <= 1'b1;
            end
            if (w_step && w_fire) begin
                r_pend_v <= 1'b1;
            end else if (w_push_end) begin
                r_pend_v <= 1'b0;
            end
            if (w_push_mid || w_push_end) begin
                r_out_v <= 1'b1;
            end else if (o_res.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req.req_type    <= i_req.req_type;
            r_req.timer_id    <= i_req.timer_id;
            r_req.interval    <= w_ivl;
            r_req.repeat_flag <= i_req.repeat_flag;
            r_req.now         <= i_req.now_ms;
            r_req.create_dl   <= sat_add(r_time, w_ivl);
        end
        if (w_step && w_fire) begin
            r_pend_id <= w_fire_id;
        end
        if (w_push_mid || w_push_end) begin
            r_out_id   <= r_pend_id;
            r_out_last <= w_push_end;
        end
    end

    assign o_res.valid      = r_out_v;
    assign o_res.fired_id   = r_out_id;
    assign o_res.last_fired = r_out_last;

endmodule
